[src/lsig_pkg.sv]
`timescale 1ns / 1ps

package lsig_pkg;

	localparam int IN_FRAC_BITS = 10;
	localparam int OUT_WIDTH = 16;
	localparam int X_WIDTH = 16;
	localparam int K_WIDTH = 6;
	localparam int SHIFT_LIMIT = 48;
	localparam int TAYLOR_TERMS = 12;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	typedef struct packed {
		logic signed [X_WIDTH-1:0] x_value;
		logic                      last_element;
	} lsig_in_t;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] sigmoid_value;
		logic                 last_out;
	} lsig_out_t;

	// Range-reduced argument: |x| = k * ln2 + r, with r in Q0.32.
	typedef struct packed {
		logic               neg;
		logic               last;
		logic               big;
		logic [K_WIDTH-1:0] k;
		logic [31:0]        r;
	} lsig_red_t;

	// exp(-|x|) in Q0.32; the value 1.0 needs the extra bit.
	typedef struct packed {
		logic        neg;
		logic        last;
		logic [32:0] e;
	} lsig_exp_t;

endpackage

[src/lsig_reduce.sv]
`timescale 1ns / 1ps

module lsig_reduce #(
	parameter int IN_FRAC_BITS = lsig_pkg::IN_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  lsig_pkg::lsig_in_t   in_data,
	output logic                 out_valid,
	output lsig_pkg::lsig_red_t  out_data
);

	localparam int SHIFT = 32 - IN_FRAC_BITS;
	localparam int MAG_W = lsig_pkg::X_WIDTH;
	localparam int RECIP_SHIFT = MAG_W;
	localparam int RECIP_W = SHIFT + RECIP_SHIFT - 31;
	localparam logic [63:0] RECIP_WIDE =
		(64'd1 << (SHIFT + RECIP_SHIFT)) / 64'(lsig_pkg::LN2_Q32);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int K_W = lsig_pkg::K_WIDTH;
	localparam int KL_W = K_W + 32;
	localparam int T_W = MAG_W + SHIFT;
	localparam int DIFF_W = (T_W > KL_W) ? T_W : KL_W;

	// Stage 1: magnitude and the reciprocal estimate of k.
	logic [MAG_W-1:0]  x_raw;
	logic [MAG_W-1:0]  mag;
	logic [PROD_W-1:0] prod;

	logic              v_s1;
	logic              neg_s1;
	logic              last_s1;
	logic [MAG_W-1:0]  mag_s1;
	logic [PROD_W-1:0] prod_s1;

	assign x_raw = in_data.x_value;
	assign mag = x_raw[MAG_W-1] ? (~x_raw) + MAG_W'(1) : x_raw;
	assign prod = PROD_W'(mag) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= x_raw[MAG_W-1];
			last_s1 <= in_data.last_element;
			mag_s1  <= mag;
			prod_s1 <= prod;
		end
	end

	// Stage 2: the estimate is exact or one below the true quotient.
	logic [RECIP_W-1:0] kest;
	logic               kbig;
	logic [K_W-1:0]     k6;
	logic [KL_W-1:0]    kl;

	logic               v_s2;
	logic               neg_s2;
	logic               last_s2;
	logic               big_s2;
	logic [MAG_W-1:0]   mag_s2;
	logic [K_W-1:0]     k_s2;
	logic [KL_W-1:0]    kl_s2;

	assign kest = prod_s1[PROD_W-1:RECIP_SHIFT];
	assign kbig = 32'(kest) >= 32'(lsig_pkg::SHIFT_LIMIT);
	assign k6 = K_W'(kest);
	assign kl = KL_W'(k6) * KL_W'(lsig_pkg::LN2_Q32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2  <= neg_s1;
			last_s2 <= last_s1;
			big_s2  <= kbig;
			mag_s2  <= mag_s1;
			k_s2    <= k6;
			kl_s2   <= kl;
		end
	end

	// Stage 3: remainder and the single correction step.
	logic [DIFF_W-1:0] t_full;
	logic [DIFF_W-1:0] diff;
	logic [32:0]       rpre;
	logic [32:0]       rsub;
	logic              corr;

	logic                v_s3;
	lsig_pkg::lsig_red_t red_s3;

	assign t_full = DIFF_W'(mag_s2) << SHIFT;
	assign diff = t_full - DIFF_W'(kl_s2);
	assign rpre = diff[32:0];
	assign rsub = rpre - 33'(lsig_pkg::LN2_Q32);
	assign corr = rpre >= 33'(lsig_pkg::LN2_Q32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s3.neg  <= neg_s2;
			red_s3.last <= last_s2;
			red_s3.big  <= big_s2 | (corr & (k_s2 == K_W'(lsig_pkg::SHIFT_LIMIT - 1)));
			red_s3.k    <= k_s2 + K_W'(corr);
			red_s3.r    <= corr ? rsub[31:0] : rpre[31:0];
		end
	end

	assign out_valid = v_s3;
	assign out_data = red_s3;

	a_rem_below_ln2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !red_s3.big |-> red_s3.r < lsig_pkg::LN2_Q32)
		else $error("reduced argument is not below ln2");

endmodule

[src/lsig_exp.sv]
`timescale 1ns / 1ps

module lsig_exp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  lsig_pkg::lsig_red_t  in_data,
	output logic                 out_valid,
	output lsig_pkg::lsig_exp_t  out_data
);

	localparam int K_W = lsig_pkg::K_WIDTH;
	localparam int STEPS = lsig_pkg::TAYLOR_TERMS - 1;

	typedef struct packed {
		logic           neg;
		logic           last;
		logic           big;
		logic [K_W-1:0] k;
		logic [31:0]    r;
		logic [31:0]    term;
		logic [32:0]    sum;
	} lsig_tay_t;

	lsig_tay_t head;
	lsig_tay_t mul_s1 [STEPS];
	lsig_tay_t div_s2 [STEPS];
	logic      v_mul_s1 [STEPS];
	logic      v_div_s2 [STEPS];

	// The first term is r itself, so the series starts at 1 - r.
	always_comb begin
		head.neg  = in_data.neg;
		head.last = in_data.last;
		head.big  = in_data.big;
		head.k    = in_data.k;
		head.r    = in_data.r;
		head.term = in_data.r;
		head.sum  = 33'h1_0000_0000 - 33'(in_data.r);
	end

	// Each step takes two stages: term * r, then the floor division by n
	// as an exact multiply by a rounded-up reciprocal.
	genvar gi;
	generate
		for (gi = 0; gi < STEPS; gi++) begin : g_step
			localparam int DIVISOR = gi + 2;
			localparam int DIV_SH = $clog2(DIVISOR);
			localparam logic [63:0] MAGIC_WIDE =
				((64'd1 << (32 + DIV_SH)) / 64'(DIVISOR)) + 64'd1;
			localparam logic [32:0] MAGIC = MAGIC_WIDE[32:0];
			localparam bit ADD_TERM = (DIVISOR % 2) == 0;

			lsig_tay_t   src;
			logic        src_v;
			lsig_tay_t   mul_d;
			lsig_tay_t   div_d;
			logic [63:0] prod_a;
			logic [64:0] prod_b;
			logic [31:0] term_b;

			if (gi == 0) begin : g_head
				assign src = head;
				assign src_v = in_valid;
			end else begin : g_link
				assign src = div_s2[gi-1];
				assign src_v = v_div_s2[gi-1];
			end

			assign prod_a = 64'(src.term) * 64'(src.r);

			always_comb begin
				mul_d = src;
				mul_d.term = prod_a[63:32];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_mul_s1[gi] <= 1'b0;
				end else if (en) begin
					v_mul_s1[gi] <= src_v;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					mul_s1[gi] <= mul_d;
				end
			end

			assign prod_b = 65'(mul_s1[gi].term) * 65'(MAGIC);
			assign term_b = 32'(prod_b >> (32 + DIV_SH));

			always_comb begin
				div_d = mul_s1[gi];
				div_d.term = term_b;
				if (ADD_TERM) begin
					div_d.sum = mul_s1[gi].sum + 33'(term_b);
				end else begin
					div_d.sum = mul_s1[gi].sum - 33'(term_b);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_div_s2[gi] <= 1'b0;
				end else if (en) begin
					v_div_s2[gi] <= v_mul_s1[gi];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					div_s2[gi] <= div_d;
				end
			end
		end
	endgenerate

	// Undo the range reduction: scale by 2^-k.
	lsig_tay_t           tail;
	logic [32:0]         e_shift;
	logic                v_res_s3;
	lsig_pkg::lsig_exp_t res_s3;

	assign tail = div_s2[STEPS-1];
	assign e_shift = tail.big ? 33'd0 : (tail.sum >> tail.k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_res_s3 <= 1'b0;
		end else if (en) begin
			v_res_s3 <= v_div_s2[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3.neg  <= tail.neg;
			res_s3.last <= tail.last;
			res_s3.e    <= e_shift;
		end
	end

	assign out_valid = v_res_s3;
	assign out_data = res_s3;

	a_exp_at_most_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_res_s3 |-> res_s3.e <= 33'h1_0000_0000)
		else $error("exponential exceeds one");

endmodule

[src/lsig_div.sv]
`timescale 1ns / 1ps

module lsig_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  lsig_pkg::lsig_exp_t  in_data,
	output logic                 out_valid,
	output lsig_pkg::lsig_out_t  out_data
);

	localparam int W = lsig_pkg::OUT_WIDTH;
	localparam int RW = W + 34;
	localparam int STEPS = W + 1;

	typedef struct packed {
		logic          last;
		logic [33:0]   den;
		logic [RW-1:0] rem;
		logic [W:0]    quo;
	} lsig_dv_t;

	lsig_dv_t    prep;
	logic [33:0] den;
	logic [32:0] num;
	lsig_dv_t    dv_s [STEPS+1];
	logic        v_dv_s [STEPS+1];

	// Dividend carries half the divisor so the quotient rounds half up.
	assign den = 34'h1_0000_0000 + 34'(in_data.e);
	assign num = in_data.neg ? in_data.e : 33'h1_0000_0000;

	always_comb begin
		prep.last = in_data.last;
		prep.den  = den;
		prep.rem  = (RW'(num) << W) + RW'(den >> 1);
		prep.quo  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_dv_s[0] <= 1'b0;
		end else if (en) begin
			v_dv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= prep;
		end
	end

	// Restoring division, one quotient bit per stage, most significant first.
	genvar gj;
	generate
		for (gj = 0; gj < STEPS; gj++) begin : g_bit
			localparam int BIT = W - gj;

			logic [RW-1:0] sub;
			logic          ge;
			lsig_dv_t      nxt;

			assign sub = RW'(dv_s[gj].den) << BIT;
			assign ge = dv_s[gj].rem >= sub;

			always_comb begin
				nxt = dv_s[gj];
				nxt.rem = ge ? dv_s[gj].rem - sub : dv_s[gj].rem;
				nxt.quo[BIT] = ge;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_dv_s[gj+1] <= 1'b0;
				end else if (en) begin
					v_dv_s[gj+1] <= v_dv_s[gj];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_s[gj+1] <= nxt;
				end
			end
		end
	endgenerate

	// A quotient of exactly one saturates to full scale.
	assign out_valid = v_dv_s[STEPS];
	assign out_data.sigmoid_value = dv_s[STEPS].quo[W] ? '1 : dv_s[STEPS].quo[W-1:0];
	assign out_data.last_out = dv_s[STEPS].last;

	a_quo_at_most_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_dv_s[STEPS] |-> !dv_s[STEPS].quo[W] || dv_s[STEPS].quo[W-1:0] == '0)
		else $error("quotient exceeds one");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_dv_s[STEPS] |-> dv_s[STEPS].rem < RW'(dv_s[STEPS].den))
		else $error("final remainder not below divisor");

endmodule

[src/logistic_sigmoid_unit.sv]
`timescale 1ns / 1ps

// Channel  Dir  Handshake                     Payload
// sample   in   sample_valid / sample_ready   lsig_in_t  (x_value, last_element)
// result   out  result_valid / result_ready   lsig_out_t (sigmoid_value, last_out)
//
// Takes one request per cycle while sample_ready is high; its result then passes
// through three reduction stages, eleven two-stage Taylor steps plus a shift stage,
// and OUT_WIDTH + 2 divider stages.
// arst_n clears every valid bit and the skid register; data registers are not reset.
// When result_ready is low, one result parks in the skid register and from the next
// cycle the whole pipeline holds, with sample_ready low, until that result drains.

module logistic_sigmoid_unit #(
	parameter int IN_FRAC_BITS = lsig_pkg::IN_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  lsig_pkg::lsig_in_t   sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output lsig_pkg::lsig_out_t  result
);

	logic                en;
	logic                red_valid;
	lsig_pkg::lsig_red_t red_data;
	logic                exp_valid;
	lsig_pkg::lsig_exp_t exp_data;
	logic                pipe_valid;
	lsig_pkg::lsig_out_t pipe_data;
	logic                skid_q;
	lsig_pkg::lsig_out_t skid_data_q;

	assign en = !skid_q;
	assign sample_ready = en;

	lsig_reduce #(
		.IN_FRAC_BITS(IN_FRAC_BITS)
	) u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sample_valid),
		.in_data  (sample),
		.out_valid(red_valid),
		.out_data (red_data)
	);

	lsig_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (red_valid),
		.in_data  (red_data),
		.out_valid(exp_valid),
		.out_data (exp_data)
	);

	lsig_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (exp_valid),
		.in_data  (exp_data),
		.out_valid(pipe_valid),
		.out_data (pipe_data)
	);

	// The pipeline still moves in the cycle in which a stall begins; the
	// request leaving its last stage then waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			if (result_ready) begin
				skid_q <= 1'b0;
			end
		end else if (pipe_valid && !result_ready) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			skid_data_q <= pipe_data;
		end
	end

	assign result_valid = skid_q | pipe_valid;
	assign result = skid_q ? skid_data_q : pipe_data;

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_q) |-> $past(pipe_valid && !result_ready))
		else $error("skid register filled without a stalled result");

endmodule
